/* rtl/c8s_pkg.sv */
// shared types and constants for the interpreter-subset step block
// no dependencies
`timescale 1ns / 1ps
package c8s_pkg;
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_EXEC  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [11:0] PC_RESET = 12'h200;
    localparam logic [15:0] OP_CLEAR = 16'h00E0;
    localparam logic [3:0] GRP_SYS  = 4'h0;
    localparam logic [3:0] GRP_JUMP = 4'h1;
    localparam logic [3:0] GRP_SET  = 4'h6;
    localparam logic [3:0] GRP_ADD  = 4'h7;
    localparam logic [3:0] GRP_IDX  = 4'hA;
    localparam logic [3:0] GRP_DRAW = 4'hD;
    localparam logic [3:0] REG_F    = 4'hF;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_FHI   = 11'b00000000010,
        ST_FLO   = 11'b00000000100,
        ST_FWAIT = 11'b00000001000,
        ST_DEC   = 11'b00000010000,
        ST_CLR   = 11'b00000100000,
        ST_DADDR = 11'b00001000000,
        ST_DWAIT = 11'b00010000000,
        ST_DROW  = 11'b00100000000,
        ST_FRD   = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } state_t;
endpackage

/* rtl/c8s_ram.sv */
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module c8s_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

/* rtl/chip8_core_subset_step_top.sv */
// interpreter subset step block: memory, registers, frame buffer, sequencer
// depends on c8s_pkg and c8s_ram
`timescale 1ns / 1ps
// usage:
// s_axis carries one item: action (write byte, execute, read row) plus its
// operands. m_axis returns one result item per input item, in order.
// s_axis_tready is high only in idle; the block takes one item at a time.
// steps from one accepted item to the next:
//   write, read or unused action: straight to the result
//   execute of a simple or unsupported opcode: two fetch reads through
//   the single memory port, decode, execute, result
//   clear: the 32 frame rows are walked one per cycle
//   draw: per drawn sprite row a memory read, a wait and a read-modify-write
//   of the frame row, for at most fifteen rows
// the result stays in the output register until m_axis_tready; each stall
// delays the next item.
// reset clears registers, pc (0x200), index and the frame buffer at once
// (frame rows are flip-flops); memory contents stay undefined until written.
module chip8_core_subset_step_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action[1:0], mem_address[13:2], mem_data[21:14], row_select[26:22]
    input  logic [31:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // row_pixels[63:0], program_counter[75:64], index_value[87:76],
    // flag_value[95:88], redraw[96], unsupported[97]
    output logic [103:0] m_axis_tdata
);
    c8s_pkg::state_t state_reg, state_next;
    logic [7:0]  vreg_reg [16];
    logic [63:0] frame_reg [32];
    logic [11:0] pc_reg, idx_reg;
    logic [1:0]  act_reg;
    logic [4:0]  row_reg;
    logic [15:0] op_reg;
    logic [5:0]  x0_reg;
    logic [4:0]  y0_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] rowout_reg;
    logic        redraw_reg, unsup_reg, valid_reg;

    logic        ram_we;
    logic [11:0] ram_addr;
    logic [7:0]  ram_rdata;

    c8s_ram #(.WIDTH(8), .DEPTH(4096)) u_mem (
        .clk(clk), .we(ram_we), .addr(ram_addr),
        .wdata(s_axis_tdata[21:14]), .rdata(ram_rdata)
    );

    wire s_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == c8s_pkg::ST_IDLE);
    assign ram_we = s_acc && (s_axis_tdata[1:0] == c8s_pkg::ACT_WRITE);

    logic [4:0] dy;
    logic [63:0] sprite_mask, cur_row;
    assign dy = y0_reg + cnt_reg;
    assign cur_row = frame_reg[dy];
    // sprite byte aligned at bit 63 shifted right by the column, clipped
    assign sprite_mask = {ram_rdata, 56'd0} >> x0_reg;

    always_comb
    begin
        ram_addr = s_axis_tdata[13:2];
        case (state_reg)
            c8s_pkg::ST_FHI:   ram_addr = pc_reg;
            c8s_pkg::ST_FLO:   ram_addr = pc_reg + 12'd1;
            // address held so the sprite byte is still on rdata in ST_DROW
            c8s_pkg::ST_DADDR: ram_addr = idx_reg + {7'd0, cnt_reg};
            c8s_pkg::ST_DWAIT: ram_addr = idx_reg + {7'd0, cnt_reg};
            default:           ram_addr = s_axis_tdata[13:2];
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            c8s_pkg::ST_IDLE:
                if (s_acc)
                    state_next = (s_axis_tdata[1:0] == c8s_pkg::ACT_EXEC) ?
                                 c8s_pkg::ST_FHI : c8s_pkg::ST_OUT;
            c8s_pkg::ST_FHI:   state_next = c8s_pkg::ST_FLO;
            c8s_pkg::ST_FLO:   state_next = c8s_pkg::ST_FWAIT;
            c8s_pkg::ST_FWAIT: state_next = c8s_pkg::ST_DEC;
            c8s_pkg::ST_DEC:
            begin
                if (op_reg == c8s_pkg::OP_CLEAR)
                    state_next = c8s_pkg::ST_CLR;
                else if (op_reg[15:12] == c8s_pkg::GRP_DRAW)
                    state_next = c8s_pkg::ST_FRD;
                else
                    state_next = c8s_pkg::ST_OUT;
            end
            c8s_pkg::ST_FRD:
                state_next = (op_reg[3:0] == 4'd0) ? c8s_pkg::ST_OUT :
                             c8s_pkg::ST_DADDR;
            c8s_pkg::ST_CLR:
                if (cnt_reg == 5'd31) state_next = c8s_pkg::ST_OUT;
            c8s_pkg::ST_DADDR: state_next = c8s_pkg::ST_DWAIT;
            c8s_pkg::ST_DWAIT: state_next = c8s_pkg::ST_DROW;
            c8s_pkg::ST_DROW:
                if ({1'b0, cnt_reg} + 6'd1 == {2'd0, op_reg[3:0]} || dy == 5'd31)
                    state_next = c8s_pkg::ST_OUT;
                else
                    state_next = c8s_pkg::ST_DADDR;
            c8s_pkg::ST_OUT:
                if (valid_reg && m_axis_tready) state_next = c8s_pkg::ST_IDLE;
            default: state_next = c8s_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= c8s_pkg::ST_IDLE;
            pc_reg <= c8s_pkg::PC_RESET;
            idx_reg <= 12'd0;
            valid_reg <= 1'b0;
            for (int i = 0; i < 16; i++) vreg_reg[i] <= 8'd0;
            for (int i = 0; i < 32; i++) frame_reg[i] <= 64'd0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                c8s_pkg::ST_IDLE:
                    if (s_acc)
                    begin
                        act_reg <= s_axis_tdata[1:0];
                        row_reg <= s_axis_tdata[26:22];
                        redraw_reg <= 1'b0;
                        unsup_reg <= 1'b0;
                        cnt_reg <= 5'd0;
                    end
                // read data is registered, so it shows the address of the state before
                c8s_pkg::ST_FLO: op_reg[15:8] <= ram_rdata;
                c8s_pkg::ST_FWAIT:
                begin
                    op_reg[7:0] <= ram_rdata;
                    pc_reg <= pc_reg + 12'd2;
                end
                c8s_pkg::ST_DEC:
                begin
                    case (op_reg[15:12])
                        c8s_pkg::GRP_SYS:
                            if (op_reg != c8s_pkg::OP_CLEAR) unsup_reg <= 1'b1;
                        c8s_pkg::GRP_JUMP: pc_reg <= op_reg[11:0];
                        c8s_pkg::GRP_SET:  vreg_reg[op_reg[11:8]] <= op_reg[7:0];
                        c8s_pkg::GRP_ADD:
                            vreg_reg[op_reg[11:8]] <= vreg_reg[op_reg[11:8]] + op_reg[7:0];
                        c8s_pkg::GRP_IDX:  idx_reg <= op_reg[11:0];
                        c8s_pkg::GRP_DRAW: ;
                        default:           unsup_reg <= 1'b1;
                    endcase
                end
                c8s_pkg::ST_FRD:
                begin
                    x0_reg <= vreg_reg[op_reg[11:8]][5:0];
                    y0_reg <= vreg_reg[op_reg[7:4]][4:0];
                    vreg_reg[c8s_pkg::REG_F] <= 8'd0;
                end
                c8s_pkg::ST_CLR:
                begin
                    if (frame_reg[cnt_reg] != 64'd0) redraw_reg <= 1'b1;
                    frame_reg[cnt_reg] <= 64'd0;
                    cnt_reg <= cnt_reg + 5'd1;
                end
                c8s_pkg::ST_DROW:
                begin
                    if ((cur_row & sprite_mask) != 64'd0)
                        vreg_reg[c8s_pkg::REG_F] <= 8'd1;
                    if (sprite_mask != 64'd0) redraw_reg <= 1'b1;
                    frame_reg[dy] <= cur_row ^ sprite_mask;
                    cnt_reg <= cnt_reg + 5'd1;
                end
                default: ;
            endcase
            if (state_reg == c8s_pkg::ST_OUT)
            begin
                if (m_axis_tready && valid_reg) valid_reg <= 1'b0;
                else if (!valid_reg)
                begin
                    valid_reg <= 1'b1;
                    rowout_reg <= (act_reg == c8s_pkg::ACT_READ) ?
                                  frame_reg[row_reg] : 64'd0;
                end
            end
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata = {6'd0, unsup_reg, redraw_reg, vreg_reg[c8s_pkg::REG_F],
                           idx_reg, pc_reg, rowout_reg};
endmodule

/* tb/sv/chip8_core_subset_step_top_test.sv */
// self-checking testbench for the interpreter subset step block
// depends on c8s_pkg and chip8_core_subset_step_top
`timescale 1ns / 1ps
module chip8_core_subset_step_top_test;
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1650;

    typedef struct packed {
        logic [63:0] row;
        logic [11:0] pc;
        logic [11:0] idx;
        logic [7:0]  vf;
        logic        redraw;
        logic        unsup;
    } step_res_t;

    typedef struct packed {
        logic [1:0]  act;
        logic [11:0] addr;
        logic [7:0]  data;
        logic [4:0]  row;
        logic        fixed;
        step_res_t   exp;
    } dir_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;

    // shadow of the core state
    logic [7:0]  mem_img [4096];
    bit          mem_known [4096];
    logic [7:0]  vreg [16];
    logic [11:0] pc_shadow;
    logic [11:0] idx_shadow;
    logic [63:0] frame_shadow [32];

    step_res_t pending_results [$];
    dir_row_t  dir_tab [25];
    int  mismatches = 0;
    int  results_seen = 0;
    int  items_sent = 0;
    int  draws_sent = 0;
    int  idle_cycles = 0;
    int  burst_left = 0;
    bit  hold_req = 1'b0;

    chip8_core_subset_step_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic step_res_t core_step(logic [1:0] act, logic [11:0] a, logic [7:0] d,
                                            logic [4:0] rs);
        step_res_t   r;
        logic [15:0] op;
        logic [7:0]  bits;
        logic [63:0] m;
        int          x0;
        int          y0;
        r = '0;
        if (act == c8s_pkg::ACT_WRITE) begin
            mem_img[a] = d;
            mem_known[a] = 1'b1;
        end else if (act == c8s_pkg::ACT_EXEC) begin
            op = {mem_img[pc_shadow], mem_img[pc_shadow + 12'd1]};
            pc_shadow = pc_shadow + 12'd2;
            case (op[15:12])
                c8s_pkg::GRP_SYS: begin
                    if (op == c8s_pkg::OP_CLEAR) begin
                        for (int i = 0; i < 32; i++) begin
                            if (frame_shadow[i] != 0) r.redraw = 1'b1;
                            frame_shadow[i] = '0;
                        end
                    end else begin
                        r.unsup = 1'b1;
                    end
                end
                c8s_pkg::GRP_JUMP: pc_shadow = op[11:0];
                c8s_pkg::GRP_SET:  vreg[op[11:8]] = op[7:0];
                c8s_pkg::GRP_ADD:  vreg[op[11:8]] = vreg[op[11:8]] + op[7:0];
                c8s_pkg::GRP_IDX:  idx_shadow = op[11:0];
                c8s_pkg::GRP_DRAW: begin
                    // origin is taken before vf is cleared
                    x0 = vreg[op[11:8]] & 63;
                    y0 = vreg[op[7:4]] & 31;
                    vreg[c8s_pkg::REG_F] = 8'd0;
                    for (int i = 0; i < op[3:0]; i++) begin
                        if (y0 + i >= 32) break;
                        bits = mem_img[idx_shadow + 12'(i)];
                        for (int b = 0; b < 8; b++) begin
                            if (x0 + b >= 64) break;
                            if (bits[7 - b]) begin
                                m = 64'd1 << (63 - x0 - b);
                                if ((frame_shadow[y0 + i] & m) != 0)
                                    vreg[c8s_pkg::REG_F] = 8'd1;
                                frame_shadow[y0 + i] ^= m;
                                r.redraw = 1'b1;
                            end
                        end
                    end
                end
                default: r.unsup = 1'b1;
            endcase
        end else if (act == c8s_pkg::ACT_READ) begin
            r.row = frame_shadow[rs];
        end
        r.pc = pc_shadow;
        r.idx = idx_shadow;
        r.vf = vreg[c8s_pkg::REG_F];
        return r;
    endfunction

    task automatic send_item(logic [1:0] act, logic [11:0] a, logic [7:0] d, logic [4:0] rs,
                             bit fixed, step_res_t fixed_res);
        step_res_t r;
        int        gap;
        r = core_step(act, a, d, rs);
        pending_results.push_back(fixed ? fixed_res : r);
        if (burst_left == 0) begin
            burst_left = $urandom_range(30, 1);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, rs, d, a, act};
        // tready only moves at the rising edge, so the falling edge sees it settled
        forever begin
            @(negedge clk);
            if (s_axis_tready) break;
        end
        @(posedge clk);
        items_sent++;
    endtask

    function automatic logic [15:0] pick_opcode();
        logic [15:0] op;
        logic [3:0]  g;
        int          k;
        k = $urandom_range(99);
        op = 16'($urandom);
        if (k < 5) begin
            op = c8s_pkg::OP_CLEAR;
        end else if (k < 13) begin
            op[15:12] = c8s_pkg::GRP_JUMP;
            if ($urandom_range(4) == 0) op[11:0] = 12'hFFE | 12'($urandom_range(1));
        end else if (k < 33) begin
            op[15:12] = c8s_pkg::GRP_SET;
        end else if (k < 50) begin
            op[15:12] = c8s_pkg::GRP_ADD;
        end else if (k < 62) begin
            op[15:12] = c8s_pkg::GRP_IDX;
        end else if (k < 90) begin
            op[15:12] = c8s_pkg::GRP_DRAW;
        end else begin
            // groups the core skips, plus group zero other than clear
            case ($urandom_range(10))
                0: g = c8s_pkg::GRP_SYS;  1: g = 4'h2;  2: g = 4'h3;  3: g = 4'h4;
                4: g = 4'h5;              5: g = 4'h8;  6: g = 4'h9;  7: g = 4'hB;
                8: g = 4'hC;              9: g = 4'hE;  default: g = 4'hF;
            endcase
            op[15:12] = g;
            if (g == c8s_pkg::GRP_SYS && $urandom_range(1) == 0) op = 16'h00EE;
            if (op == c8s_pkg::OP_CLEAR) op = 16'h00E1;
        end
        return op;
    endfunction

    // writes the next opcode (if unwritten, else at random) and any unwritten sprite bytes, then executes
    task automatic exec_random();
        logic [15:0] op;
        logic [11:0] a;
        int          y0;
        if (!(mem_known[pc_shadow] && mem_known[pc_shadow + 12'd1])
            || $urandom_range(99) < 75) begin
            op = pick_opcode();
            send_item(c8s_pkg::ACT_WRITE, pc_shadow, op[15:8], 5'($urandom), 1'b0, '0);
            send_item(c8s_pkg::ACT_WRITE, pc_shadow + 12'd1, op[7:0], 5'($urandom), 1'b0, '0);
        end
        op = {mem_img[pc_shadow], mem_img[pc_shadow + 12'd1]};
        if (op[15:12] == c8s_pkg::GRP_DRAW) begin
            draws_sent++;
            y0 = vreg[op[7:4]] & 31;
            for (int i = 0; i < op[3:0]; i++) begin
                if (y0 + i >= 32) break;
                a = idx_shadow + 12'(i);
                if (!mem_known[a])
                    send_item(c8s_pkg::ACT_WRITE, a, 8'($urandom), 5'($urandom), 1'b0, '0);
            end
        end
        send_item(c8s_pkg::ACT_EXEC, 12'($urandom), 8'($urandom), 5'($urandom), 1'b0, '0);
    endtask

    // result checker
    always @(posedge clk) begin
        step_res_t got;
        step_res_t e;
        if (m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[63:0], m_axis_tdata[75:64], m_axis_tdata[87:76],
                   m_axis_tdata[95:88], m_axis_tdata[96], m_axis_tdata[97]};
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result item with no expectation pending");
                mismatches++;
            end else begin
                e = pending_results.pop_front();
                if (got.row != e.row) begin
                    $error("row_pixels expected %h got %h", e.row, got.row);
                    mismatches++;
                end
                if (got.pc != e.pc) begin
                    $error("program_counter expected %h got %h", e.pc, got.pc);
                    mismatches++;
                end
                if (got.idx != e.idx) begin
                    $error("index_value expected %h got %h", e.idx, got.idx);
                    mismatches++;
                end
                if (got.vf != e.vf) begin
                    $error("flag_value expected %h got %h", e.vf, got.vf);
                    mismatches++;
                end
                if (got.redraw != e.redraw) begin
                    $error("redraw expected %0d got %0d", e.redraw, got.redraw);
                    mismatches++;
                end
                if (got.unsup != e.unsup) begin
                    $error("unsupported expected %0d got %0d", e.unsup, got.unsup);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // receiver stalls: changing modes, plus a long hold-off on request
    initial begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(3);
                    left = $urandom_range(200, 20);
                end
                left--;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(1));
                    2: m_axis_tready <= ($urandom_range(9) != 0);
                    default: m_axis_tready <= ($urandom_range(5) == 0);
                endcase
            end
        end
    end

    initial begin
        int k;
        int next_pause;
        bit hold_done;
        next_pause = 400;
        hold_done = 1'b0;
        foreach (mem_img[i]) begin
            mem_img[i] = '0;
            mem_known[i] = 1'b0;
        end
        foreach (vreg[i]) vreg[i] = '0;
        foreach (frame_shadow[i]) frame_shadow[i] = '0;
        pc_shadow = c8s_pkg::PC_RESET;
        idx_shadow = '0;
        dir_tab = '{
            '{c8s_pkg::ACT_READ,  12'h000, 8'h00, 5'd0,  1'b1,
              '{64'd0, 12'h200, 12'h000, 8'd0, 1'b0, 1'b0}},
            '{c8s_pkg::ACT_READ,  12'h000, 8'h00, 5'd31, 1'b1,
              '{64'd0, 12'h200, 12'h000, 8'd0, 1'b0, 1'b0}},
            '{ACT_NONE,           12'hFFF, 8'hFF, 5'd31, 1'b1,
              '{64'd0, 12'h200, 12'h000, 8'd0, 1'b0, 1'b0}},
            '{c8s_pkg::ACT_WRITE, 12'h200, 8'h00, 5'd0,  1'b0, '0},
            '{c8s_pkg::ACT_WRITE, 12'h201, 8'hE0, 5'd0,  1'b0, '0},
            '{c8s_pkg::ACT_EXEC,  12'h000, 8'h00, 5'd0,  1'b1,
              '{64'd0, 12'h202, 12'h000, 8'd0, 1'b0, 1'b0}},
            '{c8s_pkg::ACT_WRITE, 12'h202, 8'h60, 5'd0,  1'b0, '0},
            '{c8s_pkg::ACT_WRITE, 12'h203, 8'h3C, 5'd0,  1'b0, '0},
            '{c8s_pkg::ACT_EXEC,  12'h000, 8'h00, 5'd0,  1'b0, '0},
            '{c8s_pkg::ACT_WRITE, 12'h204, 8'h61, 5'd0,  1'b0, '0},
            '{c8s_pkg::ACT_WRITE, 12'h205, 8'h1D, 5'd0,  1'b0, '0},
            '{c8s_pkg::ACT_EXEC,  12'h000, 8'h00, 5'd0,  1'b0, '0},
            '{c8s_pkg::ACT_WRITE, 12'h206, 8'hAF, 5'd0,  1'b0, '0},
            '{c8s_pkg::ACT_WRITE, 12'h207, 8'hFE, 5'd0,  1'b0, '0},
            '{c8s_pkg::ACT_EXEC,  12'h000, 8'h00, 5'd0,  1'b1,
              '{64'd0, 12'h208, 12'hFFE, 8'd0, 1'b0, 1'b0}},
            // sprite rows wrap past the top of memory
            '{c8s_pkg::ACT_WRITE, 12'hFFE, 8'hFF, 5'd0,  1'b0, '0},
            '{c8s_pkg::ACT_WRITE, 12'hFFF, 8'h81, 5'd0,  1'b0, '0},
            '{c8s_pkg::ACT_WRITE, 12'h000, 8'hC3, 5'd0,  1'b0, '0},
            // draw at column 60, row 29: clipped at the right edge
            '{c8s_pkg::ACT_WRITE, 12'h208, 8'hD0, 5'd0,  1'b0, '0},
            '{c8s_pkg::ACT_WRITE, 12'h209, 8'h13, 5'd0,  1'b0, '0},
            '{c8s_pkg::ACT_EXEC,  12'h000, 8'h00, 5'd0,  1'b0, '0},
            '{c8s_pkg::ACT_READ,  12'h000, 8'h00, 5'd31, 1'b0, '0},
            '{c8s_pkg::ACT_WRITE, 12'h20A, 8'h00, 5'd0,  1'b0, '0},
            '{c8s_pkg::ACT_WRITE, 12'h20B, 8'hEE, 5'd0,  1'b0, '0},
            '{c8s_pkg::ACT_EXEC,  12'h000, 8'h00, 5'd0,  1'b1,
              '{64'd0, 12'h20C, 12'hFFE, 8'd0, 1'b0, 1'b1}}
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_item(dir_tab[i].act, dir_tab[i].addr, dir_tab[i].data, dir_tab[i].row,
                      dir_tab[i].fixed, dir_tab[i].exp);

        while (items_sent < RANDOM_ITEMS + 25) begin
            if (!hold_done && items_sent > 300) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (items_sent >= next_pause) begin
                next_pause += 400;
                s_axis_tvalid <= 1'b0;
                wait (pending_results.size() == 0);
                @(posedge clk);
            end
            k = $urandom_range(99);
            if (k < 20)
                send_item(c8s_pkg::ACT_WRITE, 12'($urandom), 8'($urandom), 5'($urandom),
                          1'b0, '0);
            else if (k < 75)
                exec_random();
            else if (k < 96)
                send_item(c8s_pkg::ACT_READ, 12'($urandom), 8'($urandom), 5'($urandom),
                          1'b0, '0);
            else
                send_item(ACT_NONE, 12'($urandom), 8'($urandom), 5'($urandom), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (100) @(posedge clk);

        $display("sent %0d items (%0d sprite draws) with random stalls on both sides",
                 items_sent, draws_sent);
        $display("checked %0d result items, %0d field mismatches", results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

/* sim.f */
rtl/c8s_pkg.sv
rtl/c8s_ram.sv
rtl/chip8_core_subset_step_top.sv
tb/sv/chip8_core_subset_step_top_test.sv
